@@ hdl/dpq_pkg.sv @@
package dpq_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int ID_BITS_DEF  = 32;
   localparam int CMD_W        = 2;
   localparam int FIELD_W      = 32;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } dpq_state_type;

endpackage

@@ hdl/dpq_req_if.sv @@
interface dpq_req_if
   import dpq_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [FIELD_W-1:0] first_id;
   logic [FIELD_W-1:0] second_id;

   modport source (output valid, cmd, first_id, second_id, input ready);
   modport sink   (input valid, cmd, first_id, second_id, output ready);
endinterface

@@ hdl/dpq_rsp_if.sv @@
interface dpq_rsp_if;
   logic valid;
   logic ready;
   logic mutual;
   logic status;

   modport source (output valid, mutual, status, input ready);
   modport sink   (input valid, mutual, status, output ready);
endinterface

@@ hdl/directed_pair_set_mutual_query_top.sv @@
// Channel   | Dir | Handshake      | Payload
// req_if    | in  | valid / ready  | cmd, first_id, second_id
// rsp_if    | out | valid / ready  | mutual, status
//
// One request at a time. Each request walks the slot memory one entry per
// cycle (single read port with registered read data), so the scan length is
// set by CAPACITY. After reset a clearing pass empties the memory; req_if.ready
// stays low meanwhile. A held result does not block acceptance of the next request;
// only the final write-back cycle waits for the result register to drain.
module directed_pair_set_mutual_query_top
   import dpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int ID_BITS  = ID_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   dpq_req_if.sink       req_if,
   dpq_rsp_if.source     rsp_if
);

   localparam int KEY_W = 2 * ID_BITS;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);

   // slot memory: {valid, key}
   logic [KEY_W:0] mem [CAPACITY];

   dpq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  rkey_ff, rkey_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic              rhit_ff, rhit_in;
   logic              free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [KEY_W:0]    rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              mutual_ff, mutual_in;
   logic              status_ff, status_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [KEY_W:0]    wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic              out_free;

   assign rd_addr  = cnt_ff[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.mutual = mutual_ff;
   assign rsp_if.status = status_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rkey_in      = rkey_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      rhit_in      = rhit_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_addr;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      mutual_in    = mutual_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[IDX_W-1:0];
      wr_data      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // clearing pass, one slot a cycle
            wr_en = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in     = req_if.cmd;
               key_in     = {req_if.first_id[ID_BITS-1:0], req_if.second_id[ID_BITS-1:0]};
               rkey_in    = {req_if.second_id[ID_BITS-1:0], req_if.first_id[ID_BITS-1:0]};
               hit_in     = 1'b0;
               rhit_in    = 1'b0;
               free_ok_in = 1'b0;
               cnt_in     = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != CNT_END) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_data_ff[KEY_W] && rd_data_ff[KEY_W-1:0] == key_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end
               if (rd_data_ff[KEY_W] && rd_data_ff[KEY_W-1:0] == rkey_ff) begin
                  rhit_in = 1'b1;
               end
               if (!rd_data_ff[KEY_W] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end else if (cnt_ff == CNT_END) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               mutual_in    = (cmd_ff == CMD_QUERY) && hit_ff && rhit_ff;
               status_in    = (cmd_ff == CMD_INSERT) && !hit_ff && !free_ok_ff;
               state_in     = ST_IDLE;
               if (cmd_ff == CMD_INSERT && !hit_ff && free_ok_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = free_idx_ff;
                  wr_data = {1'b1, key_ff};
               end else if (cmd_ff == CMD_ERASE && hit_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = hit_idx_ff;
                  wr_data = '0;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         rhit_ff      <= 1'b0;
         free_ok_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         rhit_ff      <= rhit_in;
         free_ok_ff   <= free_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      rkey_ff     <= rkey_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      rd_idx_ff   <= rd_idx_in;
      mutual_ff   <= mutual_in;
      status_ff   <= status_in;
   end

`ifndef SYNTHESIS
   // read data only returns during a scan
   a_rd_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> state_ff == ST_SCAN)
      else $error("read return outside scan");

   // a new result only comes out of the write-back cycle
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result without write-back");

   // a result never flags both table full and mutual
   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(status_ff && mutual_ff))
      else $error("status and mutual both set");
`endif

endmodule

@@ test/tb_directed_pair_set_mutual_query_top.sv @@
`timescale 1ns / 100ps

module tb_directed_pair_set_mutual_query_top;
   import dpq_pkg::*;

   localparam int SLOTS      = CAPACITY_DEF;
   localparam int CLK_HALF   = 2;
   localparam int DRAIN_WAIT = SLOTS + 40;
   localparam int HOLD_LONG  = 3000;
   localparam int HOLD_AT    = 400;    // request count that triggers the long hold
   localparam int CALM_AT    = 1100;   // no idling from here on
   localparam int CMD_SPARE  = 3;      // unused command code

   typedef struct packed {
      logic mutual;
      logic status;
   } reply_type;

   // Mirror of the pair table plus the queue of replies it predicts.
   class pair_set_mirror;
      bit          slot_used[SLOTS];
      bit [63:0]   slot_key[SLOTS];
      reply_type   pending_replies[$];
      int          mismatches;
      int          replies_seen;
      int          drops_full;
      int          mutual_hits;

      function int lookup(bit [63:0] key);
         for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == key) return i;
         return -1;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] a,
                                 logic [FIELD_W-1:0] b);
         reply_type  rep;
         bit [63:0]  key;
         int         hit;
         int         spot;
         rep = '0;
         key = {a, b};
         spot = -1;
         if (cmd == CMD_INSERT) begin
            if (lookup(key) < 0) begin
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!slot_used[i]) spot = i;
               if (spot < 0) begin
                  rep.status = 1'b1;
                  drops_full++;
               end else begin
                  slot_used[spot] = 1'b1;
                  slot_key[spot]  = key;
               end
            end
         end else if (cmd == CMD_ERASE) begin
            hit = lookup(key);
            if (hit >= 0) slot_used[hit] = 1'b0;
         end else if (cmd == CMD_QUERY) begin
            if (lookup(key) >= 0 && lookup({b, a}) >= 0) begin
               rep.mutual = 1'b1;
               mutual_hits++;
            end
         end
         pending_replies.push_back(rep);
      endfunction

      function void check_reply(logic mutual, logic status);
         reply_type exp_rep;
         replies_seen++;
         if (pending_replies.size() == 0) begin
            $error("reply with nothing outstanding: mutual=%0b status=%0b", mutual, status);
            mismatches++;
            return;
         end
         exp_rep = pending_replies.pop_front();
         if (mutual !== exp_rep.mutual) begin
            $error("mutual: expected %0b, got %0b", exp_rep.mutual, mutual);
            mismatches++;
         end
         if (status !== exp_rep.status) begin
            $error("status: expected %0b, got %0b", exp_rep.status, status);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   dpq_req_if req_bus ();
   dpq_rsp_if rsp_bus ();

   directed_pair_set_mutual_query_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   pair_set_mirror mirror = new();

   int          requests_sent;
   bit          stimulus_done;
   bit          calm;
   bit [63:0]   filled_keys[$];    // keys from the fill phase, reused to hit the table

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Drives one request; holds valid through the handshake.
   // A random gap beforehand drops valid for a burst of cycles.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] a,
                               logic [FIELD_W-1:0] b);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.first_id  <= a;
      req_bus.second_id <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      mirror.note_request(cmd, a, b);
      requests_sent++;
      calm = (requests_sent >= CALM_AT);
   endtask

   // Response side: random stall bursts, one long hold to back the block up.
   initial begin : reply_sink
      int  stall;
      bit  held;
      held = 1'b0;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (!held && requests_sent >= HOLD_AT) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_LONG) @(posedge clock);
         end
         stall = 0;
         if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 15);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            mirror.check_reply(rsp_bus.mutual, rsp_bus.status);
      end
   end

   // Random identifier: mostly a tiny pool so pairs collide and mirror,
   // sometimes the full 32-bit range.
   function automatic logic [FIELD_W-1:0] pick_id();
      if ($urandom_range(0, 4) == 0) return $urandom();
      return $urandom_range(0, 7);
   endfunction

   initial begin : stimulus
      logic [FIELD_W-1:0] all_ones;
      logic [CMD_W-1:0]   cmd;
      logic [FIELD_W-1:0] a, b;
      bit [63:0]          k;
      int                 roll;

      all_ones          = '1;
      requests_sent     = 0;
      stimulus_done     = 1'b0;
      calm              = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_INSERT;
      req_bus.first_id  = '0;
      req_bus.second_id = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, self pair, duplicates, absent erase, spare command
      send_request(CMD_INSERT, 0, 0);
      send_request(CMD_QUERY, 0, 0);               // self pair present
      send_request(CMD_INSERT, all_ones, 0);
      send_request(CMD_QUERY, all_ones, 0);        // one direction only
      send_request(CMD_INSERT, 0, all_ones);
      send_request(CMD_QUERY, all_ones, 0);        // now mutual
      send_request(CMD_INSERT, 0, all_ones);       // duplicate
      send_request(CMD_ERASE, 5, 6);               // absent
      send_request(CMD_ERASE, 0, all_ones);
      send_request(CMD_QUERY, 0, all_ones);
      send_request(CMD_SPARE, all_ones, all_ones);
      send_request(CMD_QUERY, 32'h1234_5678, 32'h8765_4321);
      send_request(CMD_INSERT, all_ones, all_ones);
      send_request(CMD_QUERY, all_ones, all_ones);
      send_request(CMD_ERASE, all_ones, all_ones);
      send_request(CMD_QUERY, all_ones, all_ones);
      send_request(CMD_ERASE, 0, 0);
      send_request(CMD_ERASE, all_ones, 0);

      // fill past capacity so the last inserts are dropped
      for (int i = 0; i < SLOTS + 6; i++) begin
         a = i + 32'h100;
         b = $urandom();
         filled_keys.push_back({a, b});
         send_request(CMD_INSERT, a, b);
      end

      // mixed traffic; erases of fill keys open slots for fresh inserts
      while (requests_sent < 1250) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)      cmd = CMD_INSERT;
         else if (roll < 70) cmd = CMD_ERASE;
         else if (roll < 95) cmd = CMD_QUERY;
         else                cmd = CMD_SPARE;
         if ($urandom_range(0, 4) == 0) begin
            k = filled_keys[$urandom_range(0, filled_keys.size() - 1)];
            a = k[63:32];
            b = k[31:0];
            if ($urandom_range(0, 1)) begin
               a = k[31:0];
               b = k[63:32];
            end
         end else begin
            a = pick_id();
            b = ($urandom_range(0, 5) == 0) ? a : pick_id();
         end
         send_request(cmd, a, b);
      end
      req_bus.valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin : wrap_up
      wait (stimulus_done);
      while (mirror.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Covered %0d requests, %0d replies: %0d inserts dropped on a full table,",
               requests_sent, mirror.replies_seen, mirror.drops_full);
      $display("%0d mutual query hits, with random stalls and one long response hold.",
               mirror.mutual_hits);
      if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
